### rtl/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and codes of the getblk buffer cache: transfer payloads,
// slot record layout, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bcg_pkg;

  localparam int NUM_BUFFERS_DEF = 8;
  localparam int BLOCK_RANGE_DEF = 128;
  localparam int BLK_W           = 7;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int OUT_IDX_W       = 3;
  localparam int BLK_SPAN        = 1 << BLK_W;

  // request codes
  localparam logic [FUNC_W-1:0] FN_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REL   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_WDONE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REL_ERR  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WDONE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_WB_START = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  block_number;
    logic              mark_delayed;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] buffer_index;
    logic [BLK_W-1:0]     result_block;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] tag;
    logic             busy;
    logic             locked;
    logic             dirty;
  } slot_rec_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_TSCAN,
    S_DECIDE,
    S_FSCAN,
    S_SH_RD,
    S_SH_WR,
    S_HITFIN,
    S_POP,
    S_POP_WAIT,
    S_VIC
  } state_t;

endpackage

### rtl/bcg_ram.sv
// ----------------------------------------------------------------------------
// bcg_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/buffer_cache_getblk.sv
// ----------------------------------------------------------------------------
// buffer_cache_getblk
// Disk-block buffer cache with getblk-style allocation, release and
// write-back completion over NUM_BUFFERS slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results come out
// as one-cycle out_valid pulses that the receiver must take as they come,
// and the last one of a request carries last = 1. Slot records (tag and
// busy/locked/dirty flags) live in one RAM and the LRU free list in a
// second RAM used as a circular queue; each request is a short sequence
// of read, modify and write-back steps on those RAMs. A request holds busy
// while it looks up its tag (one slot read per cycle) and decides. A hit on
// a free slot then finds and closes the gap in the free list; a miss pops
// free-list entries from the head and gives one write-back start per dirty
// buffer met, until a clean buffer is allocated or the list runs dry. A
// request with an unused function code is dropped in the cycle it is taken.
// After reset the block fills both RAMs, with busy held high.
// ----------------------------------------------------------------------------
module buffer_cache_getblk #(
  parameter int NUM_BUFFERS = bcg_pkg::NUM_BUFFERS_DEF,
  parameter int BLOCK_RANGE = bcg_pkg::BLOCK_RANGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bcg_pkg::in_item_t   in_data,
  output logic                out_valid,
  output bcg_pkg::out_item_t  out_data
);

  import bcg_pkg::*;

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam int RW = $bits(slot_rec_t);
  localparam logic [IW:0] NB = (IW+1)'(NUM_BUFFERS);

  // block number modulo BLOCK_RANGE, as a constant table
  logic [BLK_W-1:0] mod_lut [BLK_SPAN];

  for (genvar g = 0; g < BLK_SPAN; g++) begin : g_mod
    assign mod_lut[g] = BLK_W'(g % BLOCK_RANGE);
  end

  // sequencer registers
  state_t          state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [BLK_W-1:0]  bno_r, bno_nxt;
  logic              md_r, md_nxt;
  logic [IW:0]       idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hslot_r, hslot_nxt;
  slot_rec_t         hrec_r, hrec_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW:0]       pos_r, pos_nxt;
  logic [IW-1:0]     vic_r, vic_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // RAM ports
  logic              s_we, s_re;
  logic [IW-1:0]     s_wa, s_ra;
  slot_rec_t         s_wd, s_rd;
  logic              f_we, f_re;
  logic [IW-1:0]     f_wa, f_ra, f_wd, f_rd;

  logic [IW:0]       head_ext, cnt_ext, prev_idx, pos_inc;
  logic              s_match;
  logic              accept;

  bcg_ram #(.WIDTH(RW), .DEPTH(NUM_BUFFERS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_wa),
    .wdata (s_wd),
    .re    (s_re),
    .raddr (s_ra),
    .rdata (s_rd)
  );

  bcg_ram #(.WIDTH(IW), .DEPTH(NUM_BUFFERS)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_wa),
    .wdata (f_wd),
    .re    (f_re),
    .raddr (f_ra),
    .rdata (f_rd)
  );

  // circular queue position: inputs stay below twice the depth
  function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] x);
    logic [IW:0] y;
    y = (x >= NB) ? (x - NB) : x;
    return y[IW-1:0];
  endfunction

  function automatic out_item_t mk_out(input logic [STATUS_W-1:0] st,
                                       input logic [IW-1:0] idx,
                                       input logic [BLK_W-1:0] blk,
                                       input logic lst);
    out_item_t o;
    o.status       = st;
    o.buffer_index = OUT_IDX_W'(idx);
    o.result_block = blk;
    o.last         = lst;
    return o;
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign head_ext = (IW+1)'(head_r);
  assign cnt_ext  = (IW+1)'(cnt_r);
  assign prev_idx = idx_r - 1'b1;
  assign pos_inc  = pos_r + 1'b1;
  // a write-done lookup only counts locked slots
  assign s_match  = (s_rd.tag == bno_r) && ((func_r != FN_WDONE) || s_rd.locked);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    bno_r      <= bno_nxt;
    md_r       <= md_nxt;
    hslot_r    <= hslot_nxt;
    hrec_r     <= hrec_nxt;
    vic_r      <= vic_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    bno_nxt       = bno_r;
    md_nxt        = md_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    hit_nxt       = hit_r;
    hslot_nxt     = hslot_r;
    hrec_nxt      = hrec_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    vic_nxt       = vic_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    s_we = 1'b0;  s_wa = '0;  s_wd = '0;  s_re = 1'b0;  s_ra = '0;
    f_we = 1'b0;  f_wa = '0;  f_wd = '0;  f_re = 1'b0;  f_ra = '0;

    case (state_r)
      S_INIT: begin
        // fill slot i with block i+1, free list in slot order
        s_we = 1'b1;
        s_wa = idx_r[IW-1:0];
        s_wd.tag    = mod_lut[BLK_W'(idx_r + 1'b1)];
        s_wd.busy   = 1'b0;
        s_wd.locked = 1'b0;
        s_wd.dirty  = 1'b0;
        f_we = 1'b1;
        f_wa = idx_r[IW-1:0];
        f_wd = idx_r[IW-1:0];
        if (idx_r == NB - 1'b1) begin
          head_nxt  = '0;
          cnt_nxt   = CW'(NUM_BUFFERS);
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          func_nxt = in_data.func;
          bno_nxt  = mod_lut[in_data.block_number];
          md_nxt   = in_data.mark_delayed;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          // drop unused function codes right here
          if (in_data.func == FN_GET || in_data.func == FN_REL ||
              in_data.func == FN_WDONE) begin
            state_nxt = S_TSCAN;
          end
        end
      end

      S_TSCAN: begin
        // stream slot reads, compare each result in the cycle after its read
        if (idx_r < NB) begin
          s_re     = 1'b1;
          s_ra     = idx_r[IW-1:0];
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (s_match) begin
            hit_nxt   = 1'b1;
            hslot_nxt = prev_idx[IW-1:0];
            hrec_nxt  = s_rd;
            pend_nxt  = 1'b0;
            state_nxt = S_DECIDE;
          end else if (idx_r == NB) begin
            hit_nxt   = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        case (func_r)
          FN_GET: begin
            if (hit_r && (hrec_r.busy || hrec_r.locked)) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_out(ST_BUSY, hslot_r, hrec_r.tag, 1'b1);
              state_nxt     = S_IDLE;
            end else if (hit_r) begin
              pos_nxt   = '0;
              state_nxt = S_FSCAN;
            end else begin
              state_nxt = S_POP;
            end
          end
          FN_REL: begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            if (!hit_r) begin
              out_data_nxt = mk_out(ST_REL_ERR, '0, bno_r, 1'b1);
            end else if (!hrec_r.busy || hrec_r.locked) begin
              out_data_nxt = mk_out(ST_REL_ERR, hslot_r, bno_r, 1'b1);
            end else begin
              s_we        = 1'b1;
              s_wa        = hslot_r;
              s_wd        = hrec_r;
              s_wd.busy   = 1'b0;
              s_wd.dirty  = hrec_r.dirty | md_r;
              // append at the LRU tail
              if (cnt_r < CW'(NUM_BUFFERS)) begin
                f_we    = 1'b1;
                f_wa    = wrap_idx(head_ext + cnt_ext);
                f_wd    = hslot_r;
                cnt_nxt = cnt_r + 1'b1;
              end
              out_data_nxt = mk_out(ST_RELEASED, hslot_r, hrec_r.tag, 1'b1);
            end
          end
          FN_WDONE: begin
            state_nxt = S_IDLE;
            if (hit_r) begin
              s_we        = 1'b1;
              s_wa        = hslot_r;
              s_wd        = hrec_r;
              s_wd.busy   = 1'b0;
              s_wd.locked = 1'b0;
              s_wd.dirty  = 1'b0;
              // push at the head: reused first
              if (cnt_r < CW'(NUM_BUFFERS)) begin
                head_nxt = wrap_idx(head_ext + NB - 1'b1);
                f_we     = 1'b1;
                f_wa     = wrap_idx(head_ext + NB - 1'b1);
                f_wd     = hslot_r;
                cnt_nxt  = cnt_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = mk_out(ST_WDONE, hslot_r, hrec_r.tag, 1'b1);
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FSCAN: begin
        // locate the hit slot in the free list
        if (pend_r && (f_rd == hslot_r)) begin
          pos_nxt   = pos_r - 1'b1;
          state_nxt = S_SH_RD;
        end else if (pos_r >= cnt_ext) begin
          state_nxt = S_HITFIN;
        end else begin
          f_re     = 1'b1;
          f_ra     = wrap_idx(head_ext + pos_r);
          pos_nxt  = pos_inc;
          pend_nxt = 1'b1;
        end
      end

      S_SH_RD: begin
        // close the gap: move the next entry down one place
        if (pos_inc < cnt_ext) begin
          f_re      = 1'b1;
          f_ra      = wrap_idx(head_ext + pos_inc);
          state_nxt = S_SH_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_HITFIN;
        end
      end

      S_SH_WR: begin
        f_we      = 1'b1;
        f_wa      = wrap_idx(head_ext + pos_r);
        f_wd      = f_rd;
        pos_nxt   = pos_inc;
        state_nxt = S_SH_RD;
      end

      S_HITFIN: begin
        s_we          = 1'b1;
        s_wa          = hslot_r;
        s_wd          = hrec_r;
        s_wd.busy     = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_out(ST_ALLOC, hslot_r, hrec_r.tag, 1'b1);
        state_nxt     = S_IDLE;
      end

      S_POP: begin
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(ST_NOFREE, '0, bno_r, 1'b1);
          state_nxt     = S_IDLE;
        end else begin
          f_re      = 1'b1;
          f_ra      = head_r;
          head_nxt  = wrap_idx(head_ext + 1'b1);
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        vic_nxt   = f_rd;
        s_re      = 1'b1;
        s_ra      = f_rd;
        state_nxt = S_VIC;
      end

      S_VIC: begin
        s_we = 1'b1;
        s_wa = vic_r;
        s_wd = s_rd;
        out_valid_nxt = 1'b1;
        if (s_rd.dirty) begin
          // lock for write-back, keep draining the free list
          s_wd.locked  = 1'b1;
          out_data_nxt = mk_out(ST_WB_START, vic_r, s_rd.tag, 1'b0);
          state_nxt    = S_POP;
        end else begin
          s_wd.tag     = bno_r;
          s_wd.busy    = 1'b1;
          out_data_nxt = mk_out(ST_ALLOC, vic_r, bno_r, 1'b1);
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // results only come out of request processing
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without a request in progress");

  // only a write-back start leaves more results to follow
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.status == ST_WB_START))
    else $error("non-final result with a final status");

  // free list never holds more than every slot
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_BUFFERS))
    else $error("free list count overflow");

  // a get request keeps the block busy for its lookup
  a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FN_GET) |=> busy)
    else $error("get request not taken into processing");

endmodule

### tb/sv/buffer_cache_getblk_tb.sv
// ----------------------------------------------------------------------------
// buffer_cache_getblk_tb
// Self-checking bench for the getblk buffer cache. Gets, releases and
// write-back completions are queued up front and sent in bursts; a
// predictor keeps its own copy of the slot flags and the LRU free list,
// and each out_valid pulse is compared field by field with the oldest
// predicted transfer.
// ----------------------------------------------------------------------------
module buffer_cache_getblk_tb;
  import bcg_pkg::*;

  localparam int NBUF = NUM_BUFFERS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // function code the block does not use
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;

  buffer_cache_getblk dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor state: slot flags and the free list, head at index 0.
  logic [BLK_W-1:0] cache_tag [NBUF];
  logic             cache_busy [NBUF];
  logic             cache_locked [NBUF];
  logic             cache_dirty [NBUF];
  int               lru_list [$];

  in_item_t  pending_reqs [$];
  out_item_t expected_results [$];
  int        fail_count;
  int        cycle_count;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic void expect_result(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void queue_req(in_item_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Slot i holds block i+1, all flags clear, free list in slot order.
  function automatic void reset_model();
    lru_list.delete();
    for (int i = 0; i < NBUF; i++) begin
      cache_tag[i] = BLK_W'((i + 1) % BLOCK_RANGE_DEF);
      cache_busy[i] = 1'b0;
      cache_locked[i] = 1'b0;
      cache_dirty[i] = 1'b0;
      lru_list.insert(lru_list.size(), i);
    end
  endfunction

  function automatic out_item_t make_result(logic [STATUS_W-1:0] st, int idx,
                                            logic [BLK_W-1:0] blk, logic lst);
    out_item_t r;
    r.status = st;
    r.buffer_index = idx[OUT_IDX_W-1:0];
    r.result_block = blk;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_slot(logic [BLK_W-1:0] blk, logic only_locked);
    for (int i = 0; i < NBUF; i++)
      if (cache_tag[i] == blk && (!only_locked || cache_locked[i])) return i;
    return -1;
  endfunction

  function automatic void unlink_free(int slot);
    for (int p = 0; p < lru_list.size(); p++)
      if (lru_list[p] == slot) begin
        lru_list.delete(p);
        return;
      end
  endfunction

  // Work out the transfers one accepted request causes.
  function automatic void predict_getblk(in_item_t req);
    int s;
    int v;
    case (req.func)
      FN_GET: begin
        s = lookup_slot(req.block_number, 1'b0);
        if (s >= 0) begin
          if (cache_busy[s] || cache_locked[s]) begin
            expect_result(make_result(ST_BUSY, s, cache_tag[s], 1'b1));
          end else begin
            unlink_free(s);
            cache_busy[s] = 1'b1;
            expect_result(make_result(ST_ALLOC, s, cache_tag[s], 1'b1));
          end
          return;
        end
        // Miss: drain the free-list head, locking dirty buffers on the way.
        while (lru_list.size() > 0) begin
          v = lru_list.pop_front();
          if (cache_dirty[v]) begin
            cache_locked[v] = 1'b1;
            expect_result(make_result(ST_WB_START, v, cache_tag[v], 1'b0));
          end else begin
            cache_tag[v] = req.block_number;
            cache_busy[v] = 1'b1;
            expect_result(make_result(ST_ALLOC, v, req.block_number, 1'b1));
            return;
          end
        end
        expect_result(make_result(ST_NOFREE, 0, req.block_number, 1'b1));
      end
      FN_REL: begin
        s = lookup_slot(req.block_number, 1'b0);
        if (s < 0) begin
          expect_result(make_result(ST_REL_ERR, 0, req.block_number, 1'b1));
        end else if (!cache_busy[s] || cache_locked[s]) begin
          expect_result(make_result(ST_REL_ERR, s, req.block_number, 1'b1));
        end else begin
          cache_busy[s] = 1'b0;
          if (req.mark_delayed) cache_dirty[s] = 1'b1;
          lru_list.insert(lru_list.size(), s);
          expect_result(make_result(ST_RELEASED, s, cache_tag[s], 1'b1));
        end
      end
      FN_WDONE: begin
        s = lookup_slot(req.block_number, 1'b1);
        if (s >= 0) begin
          cache_locked[s] = 1'b0;
          cache_dirty[s] = 1'b0;
          cache_busy[s] = 1'b0;
          lru_list.push_front(s);
          expect_result(make_result(ST_WDONE, s, cache_tag[s], 1'b1));
        end
      end
      default: ;  // unused code: dropped
    endcase
  endfunction

  function automatic in_item_t pack_req(logic [FUNC_W-1:0] f, int blk, logic md);
    in_item_t r;
    r.func = f;
    r.block_number = blk[BLK_W-1:0];
    r.mark_delayed = md;
    return r;
  endfunction

  // Fill the request queue: directed opening, then random traffic.
  initial begin
    int pick;
    int hot;
    queue_req(pack_req(FN_GET, 1, 1'b0));    // hit on free slot
    queue_req(pack_req(FN_GET, 1, 1'b0));    // hit on busy slot
    queue_req(pack_req(FN_REL, 1, 1'b1));    // release dirty
    queue_req(pack_req(FN_REL, 1, 1'b0));    // release of free block
    queue_req(pack_req(FN_REL, 127, 1'b0));  // release uncached
    queue_req(pack_req(FN_GET, 0, 1'b0));    // miss, clean head
    queue_req(pack_req(FN_GET, 127, 1'b0));  // miss
    queue_req(pack_req(FN_GET, 1, 1'b0));    // hit on free dirty slot
    queue_req(pack_req(FN_REL, 1, 1'b1));
    queue_req(pack_req(FN_REL, 0, 1'b1));
    queue_req(pack_req(FN_REL, 127, 1'b1));
    for (int b = 0; b < 5; b++)              // misses take the clean free slots
      queue_req(pack_req(FN_GET, 100 + b, 1'b0));
    queue_req(pack_req(FN_GET, 1, 1'b0));    // hit on free dirty slot
    queue_req(pack_req(FN_REL, 1, 1'b0));    // release, slot stays dirty
    queue_req(pack_req(FN_WDONE, 1, 1'b0));  // not locked: ignored
    queue_req(pack_req(FN_WDONE, 1, 1'b0));  // not locked: ignored
    queue_req(pack_req(FN_WDONE, 0, 1'b0));
    queue_req(pack_req(FN_WDONE, 127, 1'b0));
    queue_req(pack_req(FN_SPARE, 127, 1'b1)); // unused code
    for (int b = 0; b < 3; b++)              // exhaust the cache
      queue_req(pack_req(FN_GET, 110 + b, 1'b0));
    // Random part: a small hot block set keeps hits, locks and no-free cases
    // frequent; a few items use the full block range and unused codes.
    for (int n = 0; n < 200; n++) begin
      pick = $urandom_range(0, 99);
      hot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 13);
      if (pick < 40)      queue_req(pack_req(FN_GET, hot, 1'b0));
      else if (pick < 75) queue_req(pack_req(FN_REL, hot, 1'($urandom_range(0, 1))));
      else if (pick < 97) queue_req(pack_req(FN_WDONE, hot, 1'($urandom_range(0, 1))));
      else                queue_req(pack_req(FN_SPARE, hot, 1'($urandom_range(0, 1))));
    end
  end

  // Driver: bursts of random length, random gaps between them.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      reset_model();
    end else if (start && busy) begin
      // hold the request until it is taken
    end else begin
      if (start) predict_getblk(in_data);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every out_valid pulse is a transfer; compare it with the oldest
  // prediction.
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer %p", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.buffer_index !== want.buffer_index)
          report_mismatch($sformatf("buffer_index %0d, want %0d",
                                    out_data.buffer_index, want.buffer_index));
        if (out_data.result_block !== want.result_block)
          report_mismatch($sformatf("result_block %0d, want %0d",
                                    out_data.result_block, want.result_block));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", out_data.last, want.last));
      end
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired with %0d transfers outstanding", expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Wait for every request to go out and every predicted transfer to land.
    do @(posedge clk);
    while (!(pending_reqs.size() == 0 && !start && expected_results.size() == 0));
    // Let any trailing activity show up before judging.
    repeat (10 * NBUF + 20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bcg_pkg.sv
rtl/bcg_ram.sv
rtl/buffer_cache_getblk.sv
tb/sv/buffer_cache_getblk_tb.sv
